/* rtl/calendar_date_day_offset_core_macros.svh */
// assertion macros for the calendar date day offset core
`ifndef CALENDAR_DATE_DAY_OFFSET_CORE_MACROS_SVH
`define CALENDAR_DATE_DAY_OFFSET_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CDDO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CDDO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CDDO_ASSERT(lbl, prop, msg)
`define CDDO_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/cddo_pkg.sv */
// shared types, constants and calendar helper functions
`default_nettype none

package cddo_pkg;

  localparam int AluW      = 18;
  localparam int YearW     = 14;
  localparam int MonthW    = 4;
  localparam int DayW      = 5;
  localparam int OffW      = 17;
  localparam int BiasW     = 15;
  localparam int YoeW      = 9;
  localparam int StepW     = 3;

  localparam int EraYears  = 400;
  localparam int MaxYear   = 9999;
  localparam int BaseDays  = 365;
  localparam int FirstStep = 5;

  typedef logic signed [AluW-1:0] alu_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MOD,
    ST_ROFF,
    ST_YEAR,
    ST_MONTH,
    ST_FIN,
    ST_DONE
  } state_e;

  // leap test on the year taken modulo 400
  function automatic logic leap_yoe(input logic [YoeW-1:0] yoe);
    return (yoe[1:0] == 2'd0) && (yoe != 9'd100) && (yoe != 9'd200) && (yoe != 9'd300);
  endfunction

  function automatic logic [YoeW-1:0] yoe_inc(input logic [YoeW-1:0] yoe);
    return (yoe == 9'd399) ? '0 : yoe + 9'd1;
  endfunction

  function automatic logic [YoeW-1:0] yoe_dec(input logic [YoeW-1:0] yoe);
    return (yoe == 9'd0) ? 9'd399 : yoe - 9'd1;
  endfunction

  // month length, months counted from march (0) to february (11)
  function automatic logic [DayW-1:0] mlen(input logic [MonthW-1:0] mp, input logic leap);
    logic [DayW-1:0] len;
    if (mp inside {4'd1, 4'd3, 4'd6, 4'd8}) begin
      len = 5'd30;
    end else if (mp == 4'd11) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] cum(input logic [MonthW-1:0] mp);
    logic [8:0] days;
    case (mp)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* rtl/cddo_alu.sv */
// shared add/subtract unit with sign output
`default_nettype none

module cddo_alu (
  input  cddo_pkg::alu_t a_i,
  input  cddo_pkg::alu_t b_i,
  input  logic           sub_i,
  output cddo_pkg::alu_t sum_o,
  output logic           neg_o
);

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign neg_o = sum_o[cddo_pkg::AluW-1];

endmodule

`default_nettype wire

/* rtl/calendar_date_day_offset_core.sv */
// calendar date plus signed day offset, sequenced over one shared adder
`default_nettype none

// Adds a signed day offset to a Gregorian date. One transaction is taken at a time. After
// acceptance the year is biased and reduced, the day of year is folded into the offset, the
// whole years it spans are walked off (about |day_offset| / 365, up to 180) and then up to 11
// month steps in the last year; an invalid starting date stops after the fold. The next
// transaction can be accepted the cycle after the result is loaded. All arithmetic goes
// through one 18-bit add/subtract unit: six steps reduce the year modulo 400, then the
// offset is walked off one year and then one month per cycle. An invalid starting date
// returns the input with bad_input set. Results before year 0 or after 9999 are clamped to
// 0-01-01 or 9999-12-31 with out_of_range set. A finished result is held in an output
// register, so the next transaction may be accepted while it waits.

`include "calendar_date_day_offset_core_macros.svh"

module calendar_date_day_offset_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cddo_pkg::YearW-1:0]       start_year_i,
  input  logic [cddo_pkg::MonthW-1:0]      start_month_i,
  input  logic [cddo_pkg::DayW-1:0]        start_day_i,
  input  logic signed [cddo_pkg::OffW-1:0] day_offset_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [cddo_pkg::YearW-1:0]       result_year_o,
  output logic [cddo_pkg::MonthW-1:0]      result_month_o,
  output logic [cddo_pkg::DayW-1:0]        result_day_o,
  output logic                             out_of_range_o,
  output logic                             bad_input_o
);

  cddo_pkg::state_e state_q, state_d;

  logic [cddo_pkg::YearW-1:0]       y_q, y_d;
  logic [cddo_pkg::MonthW-1:0]      m_q, m_d;
  logic [cddo_pkg::DayW-1:0]        d_q, d_d;
  logic signed [cddo_pkg::OffW-1:0] off_q, off_d;
  logic [cddo_pkg::MonthW-1:0]      mp_q, mp_d;
  logic [cddo_pkg::BiasW-1:0]       yb_q, yb_d;
  logic [cddo_pkg::BiasW-1:0]       yoe_q, yoe_d;
  logic [cddo_pkg::StepW-1:0]       k_q, k_d;
  cddo_pkg::alu_t                   r_q, r_d;

  logic [cddo_pkg::YearW-1:0]  res_year_q, res_year_d;
  logic [cddo_pkg::MonthW-1:0] res_month_q, res_month_d;
  logic [cddo_pkg::DayW-1:0]   res_day_q, res_day_d;
  logic                        res_oor_q, res_oor_d;
  logic                        res_bad_q, res_bad_d;

  logic                        out_valid_q, out_valid_d;
  logic [cddo_pkg::YearW-1:0]  out_year_q;
  logic [cddo_pkg::MonthW-1:0] out_month_q;
  logic [cddo_pkg::DayW-1:0]   out_day_q;
  logic                        out_oor_q;
  logic                        out_bad_q;
  logic                        out_load;

  cddo_pkg::alu_t alu_a, alu_b, alu_sum;
  logic           alu_sub, alu_neg;

  logic [cddo_pkg::YoeW-1:0]   yoe_cur;
  logic [cddo_pkg::YoeW-1:0]   yoe_nx;
  logic                        leap_cur;
  logic                        leap_nx;
  logic [cddo_pkg::DayW-1:0]   mlen_cur;
  logic [8:0]                  day_idx;
  logic                        date_bad;

  cddo_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .neg_o (alu_neg)
  );

  assign yoe_cur  = yoe_q[cddo_pkg::YoeW-1:0];
  assign yoe_nx   = cddo_pkg::yoe_inc(yoe_cur);
  assign leap_cur = cddo_pkg::leap_yoe(yoe_cur);
  // february of the current march-based year falls in the following calendar year
  assign leap_nx  = cddo_pkg::leap_yoe(yoe_nx);
  assign mlen_cur = cddo_pkg::mlen(mp_q, leap_nx);
  assign day_idx  = cddo_pkg::cum(mp_q) + 9'(d_q) - 9'd1;
  assign date_bad = (m_q == 4'd0) || (m_q > 4'd12) || (d_q == 5'd0) || (d_q > mlen_cur);

  assign out_load = (state_q == cddo_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    y_d         = y_q;
    m_d         = m_q;
    d_d         = d_q;
    off_d       = off_q;
    mp_d        = mp_q;
    yb_d        = yb_q;
    yoe_d       = yoe_q;
    k_d         = k_q;
    r_d         = r_q;
    res_year_d  = res_year_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_oor_d   = res_oor_q;
    res_bad_d   = res_bad_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;

    case (state_q)
      cddo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          y_d     = start_year_i;
          m_d     = start_month_i;
          d_d     = start_day_i;
          off_d   = day_offset_i;
          mp_d    = (start_month_i > 4'd2) ? start_month_i - 4'd3 : start_month_i + 4'd9;
          state_d = cddo_pkg::ST_INIT;
        end
      end
      cddo_pkg::ST_INIT: begin
        // biased march-based year: january and february belong to the year before
        alu_a   = cddo_pkg::alu_t'(y_q);
        alu_b   = (m_q <= 4'd2) ? cddo_pkg::alu_t'(cddo_pkg::EraYears - 1)
                                : cddo_pkg::alu_t'(cddo_pkg::EraYears);
        yb_d    = alu_sum[cddo_pkg::BiasW-1:0];
        yoe_d   = alu_sum[cddo_pkg::BiasW-1:0];
        k_d     = cddo_pkg::StepW'(cddo_pkg::FirstStep);
        state_d = cddo_pkg::ST_MOD;
      end
      cddo_pkg::ST_MOD: begin
        // restoring reduction modulo 400
        alu_a   = cddo_pkg::alu_t'(yoe_q);
        alu_b   = cddo_pkg::alu_t'(cddo_pkg::EraYears) <<< k_q;
        alu_sub = 1'b1;
        if (!alu_neg) begin
          yoe_d = alu_sum[cddo_pkg::BiasW-1:0];
        end
        if (k_q == '0) begin
          state_d = cddo_pkg::ST_ROFF;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      cddo_pkg::ST_ROFF: begin
        // fold the day of year into the offset, counting from march 1
        alu_a = cddo_pkg::alu_t'(off_q);
        alu_b = cddo_pkg::alu_t'(day_idx);
        r_d   = alu_sum;
        mp_d  = '0;
        if (date_bad) begin
          res_year_d  = y_q;
          res_month_d = m_q;
          res_day_d   = d_q;
          res_oor_d   = 1'b0;
          res_bad_d   = 1'b1;
          state_d     = cddo_pkg::ST_DONE;
        end else begin
          state_d = cddo_pkg::ST_YEAR;
        end
      end
      cddo_pkg::ST_YEAR: begin
        if (r_q[cddo_pkg::AluW-1]) begin
          // step back one year; that span holds february of the current year
          alu_a = r_q;
          alu_b = cddo_pkg::alu_t'(cddo_pkg::BaseDays) + cddo_pkg::alu_t'(leap_cur);
          r_d   = alu_sum;
          yb_d  = yb_q - 15'd1;
          yoe_d = cddo_pkg::BiasW'(cddo_pkg::yoe_dec(yoe_cur));
        end else begin
          alu_a   = r_q;
          alu_b   = cddo_pkg::alu_t'(cddo_pkg::BaseDays) + cddo_pkg::alu_t'(leap_nx);
          alu_sub = 1'b1;
          if (!alu_neg) begin
            r_d   = alu_sum;
            yb_d  = yb_q + 15'd1;
            yoe_d = cddo_pkg::BiasW'(yoe_nx);
          end else begin
            state_d = cddo_pkg::ST_MONTH;
          end
        end
      end
      cddo_pkg::ST_MONTH: begin
        alu_a   = r_q;
        alu_b   = cddo_pkg::alu_t'(mlen_cur);
        alu_sub = 1'b1;
        if (!alu_neg) begin
          r_d  = alu_sum;
          mp_d = mp_q + 4'd1;
        end else begin
          state_d = cddo_pkg::ST_FIN;
        end
      end
      cddo_pkg::ST_FIN: begin
        // remove the bias and move january and february back to their calendar year
        alu_a     = cddo_pkg::alu_t'(yb_q) + cddo_pkg::alu_t'(mp_q >= 4'd10);
        alu_b     = cddo_pkg::alu_t'(cddo_pkg::EraYears);
        alu_sub   = 1'b1;
        res_bad_d = 1'b0;
        if (alu_neg) begin
          res_oor_d   = 1'b1;
          res_year_d  = '0;
          res_month_d = 4'd1;
          res_day_d   = 5'd1;
        end else if (alu_sum > cddo_pkg::alu_t'(cddo_pkg::MaxYear)) begin
          res_oor_d   = 1'b1;
          res_year_d  = cddo_pkg::YearW'(cddo_pkg::MaxYear);
          res_month_d = 4'd12;
          res_day_d   = 5'd31;
        end else begin
          res_oor_d   = 1'b0;
          res_year_d  = alu_sum[cddo_pkg::YearW-1:0];
          res_month_d = (mp_q < 4'd10) ? mp_q + 4'd3 : mp_q - 4'd9;
          res_day_d   = r_q[cddo_pkg::DayW-1:0] + 5'd1;
        end
        state_d = cddo_pkg::ST_DONE;
      end
      cddo_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = cddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cddo_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cddo_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    m_q         <= m_d;
    d_q         <= d_d;
    off_q       <= off_d;
    mp_q        <= mp_d;
    yb_q        <= yb_d;
    yoe_q       <= yoe_d;
    k_q         <= k_d;
    r_q         <= r_d;
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_oor_q   <= res_oor_d;
    res_bad_q   <= res_bad_d;
    if (out_load) begin
      out_year_q  <= res_year_q;
      out_month_q <= res_month_q;
      out_day_q   <= res_day_q;
      out_oor_q   <= res_oor_q;
      out_bad_q   <= res_bad_q;
    end
  end

  assign in_stall_o     = (state_q != cddo_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_year_o  = out_year_q;
  assign result_month_o = out_month_q;
  assign result_day_o   = out_day_q;
  assign out_of_range_o = out_oor_q;
  assign bad_input_o    = out_bad_q;

  `CDDO_ASSERT(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o,
               "accepted transaction did not start the sequencer")
  `CDDO_ASSERT(a_month_step_bound, (state_q == cddo_pkg::ST_MONTH) |-> (mp_q <= 4'd11),
               "month walk ran past february")
  `CDDO_ASSERT(a_result_from_done,
               $rose(out_valid_o) |-> $past(state_q == cddo_pkg::ST_DONE),
               "result shown without a finished transaction")
  `CDDO_ASSERT(a_valid_result_date,
               (out_valid_o && !bad_input_o) |-> (result_month_o >= 4'd1 &&
                 result_month_o <= 4'd12 && result_day_o >= 5'd1),
               "computed date out of calendar range")
  `CDDO_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!out_valid_o && !in_stall_o),
                      "block not idle in reset")

endmodule

`default_nettype wire
